FILE: rtl/core/ceta_pkg.sv
// ----------------------------------------------------------------------------
// ceta_pkg
// Shared types, constants and the month-length lookup for the elapsed-time
// calendar advance block.
// ----------------------------------------------------------------------------
package ceta_pkg;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NO_TIME  = 1'b1;

   // x / 1000 = (x * MS_RECIP) >> MS_SHIFT, exact for any 32-bit x
   localparam logic [28:0] MS_RECIP = 29'h10624DD3;
   localparam int          MS_SHIFT = 38;

   // x / 60 and x / 24 by reciprocal, exact for x < 2^23
   localparam logic [24:0] DIV60_RECIP = 25'd8947849;
   localparam logic [24:0] DIV24_RECIP = 25'd22369622;
   localparam int          DIV_SHIFT   = 29;

   // y / 25, exact for any 16-bit y
   localparam logic [16:0] DIV25_RECIP = 17'd83887;
   localparam int          DIV25_SHIFT = 21;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MS,
      ST_SADD,
      ST_QUO,
      ST_REM,
      ST_LEAP,
      ST_MONTH,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      UNIT_SEC,
      UNIT_MIN,
      UNIT_HOUR
   } unit_type;

   typedef struct packed {
      logic     accept;
      logic     ms_div;
      logic     sec_add;
      logic     quo;
      logic     rem;
      logic     leap;
      logic     month_step;
      logic     out_load;
      unit_type unit;
   } cmd_type;

   typedef struct packed {
      logic time_valid;
      logic days_zero;
      logic year_wrap;
      logic rsp_free;
   } stat_type;

   function automatic logic [4:0] days_in(input logic [3:0] mon, input logic leap);
      logic [4:0] d;
      unique case (mon)
         MONTH_FEB:                 d = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
         default:                   d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

FILE: rtl/core/ceta_ctrl.sv
// ----------------------------------------------------------------------------
// ceta_ctrl
// Sequencer: steps the datapath through the divide, carry and month loops.
// ----------------------------------------------------------------------------
module ceta_ctrl
   import ceta_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_type,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   unit_type  unit_ff, unit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         unit_ff  <= UNIT_SEC;
      end else begin
         state_ff <= state_in;
         unit_ff  <= unit_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      unit_in   = unit_ff;
      cmd       = '0;
      cmd.unit  = unit_ff;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_type == REQ_QUERY && !stat.time_valid)
                  state_in = ST_OUT;
               else
                  state_in = ST_MS;
            end
         end
         ST_MS: begin
            cmd.ms_div = 1'b1;
            state_in   = ST_SADD;
         end
         ST_SADD: begin
            cmd.sec_add = 1'b1;
            unit_in     = UNIT_SEC;
            state_in    = ST_QUO;
         end
         ST_QUO: begin
            cmd.quo  = 1'b1;
            state_in = ST_REM;
         end
         ST_REM: begin
            cmd.rem = 1'b1;
            unique case (unit_ff)
               UNIT_SEC: begin
                  unit_in  = UNIT_MIN;
                  state_in = ST_QUO;
               end
               UNIT_MIN: begin
                  unit_in  = UNIT_HOUR;
                  state_in = ST_QUO;
               end
               default: state_in = ST_LEAP;
            endcase
         end
         ST_LEAP: begin
            cmd.leap = 1'b1;
            state_in = ST_MONTH;
         end
         ST_MONTH: begin
            if (stat.days_zero) begin
               state_in = ST_OUT;
            end else begin
               cmd.month_step = 1'b1;
               // new year: leap flag must be recomputed first
               if (stat.year_wrap)
                  state_in = ST_LEAP;
            end
         end
         ST_OUT: begin
            if (stat.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: rtl/core/ceta_dp.sv
// ----------------------------------------------------------------------------
// ceta_dp
// Datapath: stored time, reciprocal dividers, carry chain, month stepper and
// the result register.
// ----------------------------------------------------------------------------
module ceta_dp
   import ceta_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic        req_type,
   input  logic [31:0] req_now_ms,
   input  logic [15:0] req_in_year,
   input  logic [3:0]  req_in_month,
   input  logic [4:0]  req_in_day,
   input  logic [4:0]  req_in_hour,
   input  logic [5:0]  req_in_minute,
   input  logic [5:0]  req_in_second,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [15:0] rsp_out_year,
   output logic [3:0]  rsp_out_month,
   output logic [4:0]  rsp_out_day,
   output logic [4:0]  rsp_out_hour,
   output logic [5:0]  rsp_out_minute,
   output logic [5:0]  rsp_out_second
);

   // stored time
   logic        valid_ff;
   logic [15:0] base_year_ff;
   logic [3:0]  base_month_ff;
   logic [4:0]  base_day_ff;
   logic [4:0]  base_hour_ff;
   logic [5:0]  base_minute_ff;
   logic [5:0]  base_second_ff;
   logic [31:0] stamp_ff;

   // working registers
   logic        nv_ff;
   logic [31:0] elapsed_ff;
   logic [22:0] secs_ff;
   logic [22:0] acc_ff;
   logic [18:0] quo_ff;
   logic [11:0] q25_ff;
   logic [6:0]  days_ff;
   logic [15:0] year_ff;
   logic [3:0]  mon_ff;
   logic [4:0]  day_ff;
   logic [4:0]  hr_ff;
   logic [5:0]  mn_ff;
   logic [5:0]  sc_ff;

   // result register
   logic        rsp_valid_ff;
   logic        rsp_status_ff;
   logic [15:0] rsp_year_ff;
   logic [3:0]  rsp_month_ff;
   logic [4:0]  rsp_day_ff;
   logic [4:0]  rsp_hour_ff;
   logic [5:0]  rsp_minute_ff;
   logic [5:0]  rsp_second_ff;

   logic [60:0] ms_prod;
   logic [47:0] div_prod;
   logic [24:0] div_recip;
   logic [24:0] quo_times;
   logic [22:0] rem;
   logic [32:0] y25_prod;
   logic [16:0] q25_times;
   logic        d25;
   logic        leap;
   logic [4:0]  dim;
   logic [5:0]  left;
   logic [7:0]  sum;

   assign ms_prod   = 61'(elapsed_ff) * 61'(MS_RECIP);
   assign div_recip = (cmd.unit == UNIT_HOUR) ? DIV24_RECIP : DIV60_RECIP;
   assign div_prod  = 48'(acc_ff) * 48'(div_recip);

   // quotient times divisor by shifts: 60 = 64 - 4, 24 = 16 + 8
   assign quo_times = (cmd.unit == UNIT_HOUR)
                    ? ({2'b0, quo_ff, 4'b0} + {3'b0, quo_ff, 3'b0})
                    : ({quo_ff, 6'b0} - {4'b0, quo_ff, 2'b0});
   assign rem = acc_ff - quo_times[22:0];

   assign y25_prod  = 33'(year_ff) * 33'(DIV25_RECIP);
   assign q25_times = {1'b0, q25_ff, 4'b0} + {2'b0, q25_ff, 3'b0} + {5'b0, q25_ff};
   assign d25       = ({1'b0, year_ff} == q25_times);
   assign leap      = ((year_ff[1:0] == 2'b00) && !d25) || ((year_ff[3:0] == 4'b0) && d25);

   assign dim  = days_in(mon_ff, leap);
   assign left = (day_ff <= dim) ? (6'(dim) - 6'(day_ff) + 6'd1) : 6'd1;
   assign sum  = 8'(day_ff) + 8'(days_ff);

   assign stat.time_valid = valid_ff;
   assign stat.days_zero  = (days_ff == 7'd0);
   assign stat.year_wrap  = (days_ff != 7'd0) && (sum > 8'(dim)) && (mon_ff >= MONTH_DEC);
   assign stat.rsp_free   = !rsp_valid_ff || !rsp_stall;

   // stored time
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         base_year_ff   <= '0;
         base_month_ff  <= MONTH_JAN;
         base_day_ff    <= 5'd1;
         base_hour_ff   <= '0;
         base_minute_ff <= '0;
         base_second_ff <= '0;
         stamp_ff       <= '0;
      end else if (cmd.accept && req_type == REQ_LOAD) begin
         valid_ff       <= 1'b1;
         base_year_ff   <= req_in_year;
         base_month_ff  <= req_in_month;
         base_day_ff    <= req_in_day;
         base_hour_ff   <= req_in_hour;
         base_minute_ff <= req_in_minute;
         base_second_ff <= req_in_second;
         stamp_ff       <= req_now_ms;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         nv_ff      <= (req_type == REQ_QUERY) && !valid_ff;
         elapsed_ff <= (req_type == REQ_LOAD) ? 32'd0 : (req_now_ms - stamp_ff);
      end
      if (cmd.ms_div)
         secs_ff <= ms_prod[60:MS_SHIFT];
      if (cmd.sec_add) begin
         acc_ff  <= 23'(base_second_ff) + secs_ff;
         year_ff <= base_year_ff;
         mon_ff  <= base_month_ff;
         day_ff  <= base_day_ff;
      end
      if (cmd.quo)
         quo_ff <= div_prod[DIV_SHIFT+18:DIV_SHIFT];
      if (cmd.rem) begin
         unique case (cmd.unit)
            UNIT_SEC: begin
               sc_ff  <= rem[5:0];
               acc_ff <= 23'(quo_ff) + 23'(base_minute_ff);
            end
            UNIT_MIN: begin
               mn_ff  <= rem[5:0];
               acc_ff <= 23'(quo_ff) + 23'(base_hour_ff);
            end
            default: begin
               hr_ff   <= rem[4:0];
               days_ff <= quo_ff[6:0];
            end
         endcase
      end
      if (cmd.leap)
         q25_ff <= y25_prod[DIV25_SHIFT+11:DIV25_SHIFT];
      if (cmd.month_step) begin
         if (sum <= 8'(dim)) begin
            day_ff  <= sum[4:0];
            days_ff <= '0;
         end else begin
            days_ff <= days_ff - 7'(left);
            day_ff  <= 5'd1;
            if (mon_ff >= MONTH_DEC) begin
               mon_ff  <= MONTH_JAN;
               year_ff <= year_ff + 16'd1;
            end else begin
               mon_ff <= mon_ff + 4'd1;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.out_load)
         rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (nv_ff) begin
            rsp_status_ff <= STATUS_NO_TIME;
            rsp_year_ff   <= '0;
            rsp_month_ff  <= '0;
            rsp_day_ff    <= '0;
            rsp_hour_ff   <= '0;
            rsp_minute_ff <= '0;
            rsp_second_ff <= '0;
         end else begin
            rsp_status_ff <= STATUS_OK;
            rsp_year_ff   <= year_ff;
            rsp_month_ff  <= mon_ff;
            rsp_day_ff    <= day_ff;
            rsp_hour_ff   <= hr_ff;
            rsp_minute_ff <= mn_ff;
            rsp_second_ff <= sc_ff;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_year   = rsp_year_ff;
   assign rsp_out_month  = rsp_month_ff;
   assign rsp_out_day    = rsp_day_ff;
   assign rsp_out_hour   = rsp_hour_ff;
   assign rsp_out_minute = rsp_minute_ff;
   assign rsp_out_second = rsp_second_ff;

endmodule

FILE: rtl/core/calendar_elapsed_time_advance_top.sv
// ----------------------------------------------------------------------------
// calendar_elapsed_time_advance_top
// Wall-clock cache: stores a date/time with its millisecond stamp and answers
// queries with the stored time advanced by the elapsed whole seconds.
// ----------------------------------------------------------------------------
// req channel (req_valid/req_stall): req_type 0 loads the in_* fields and the
// stamp req_now_ms, req_type 1 queries at time req_now_ms. Every item gives
// exactly one item on the rsp channel (rsp_valid/rsp_stall); a load answers
// with the stored time after carry normalization.
// One item is in work at a time; req_stall is high from the cycle after an
// accept until the result is written to the output register.
// A query with no stored time goes straight to the output. Any other item steps
// through the millisecond divide, the seconds add, a quotient and remainder step
// per seconds/minutes/hours carry in the shared reciprocal divider, a leap check,
// day-stepper steps (one per month boundary crossed plus one when the days end
// inside a month, at most three) and a leap check per year boundary crossed.
// The output register decouples the sides: a new item is accepted while a
// finished result is held under rsp_stall; the next result waits in the
// sequencer until the register frees. Reset clears time_valid and rsp_valid.
// ----------------------------------------------------------------------------
module calendar_elapsed_time_advance_top
   import ceta_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [31:0] req_now_ms,
   input  logic [15:0] req_in_year,
   input  logic [3:0]  req_in_month,
   input  logic [4:0]  req_in_day,
   input  logic [4:0]  req_in_hour,
   input  logic [5:0]  req_in_minute,
   input  logic [5:0]  req_in_second,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [15:0] rsp_out_year,
   output logic [3:0]  rsp_out_month,
   output logic [4:0]  rsp_out_day,
   output logic [4:0]  rsp_out_hour,
   output logic [5:0]  rsp_out_minute,
   output logic [5:0]  rsp_out_second
);

   cmd_type  cmd;
   stat_type stat;

   ceta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ceta_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_type       (req_type),
      .req_now_ms     (req_now_ms),
      .req_in_year    (req_in_year),
      .req_in_month   (req_in_month),
      .req_in_day     (req_in_day),
      .req_in_hour    (req_in_hour),
      .req_in_minute  (req_in_minute),
      .req_in_second  (req_in_second),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_out_year   (rsp_out_year),
      .rsp_out_month  (rsp_out_month),
      .rsp_out_day    (rsp_out_day),
      .rsp_out_hour   (rsp_out_hour),
      .rsp_out_minute (rsp_out_minute),
      .rsp_out_second (rsp_out_second)
   );

   // one item in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while previous one still in work");

   // carry chain always leaves normalized time of day
   a_time_normalized: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_OK) |->
         (rsp_out_hour < 5'd24 && rsp_out_minute < 6'd60 && rsp_out_second < 6'd60))
      else $error("result time of day not normalized");

   a_no_time_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_NO_TIME) |->
         (rsp_out_year == 16'd0 && rsp_out_month == 4'd0 && rsp_out_day == 5'd0))
      else $error("no-time result carries nonzero date");

   // a load always leaves a valid stored time, so the next result is ok
   a_load_then_ok: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_type == REQ_LOAD) |=>
         (!rsp_valid || rsp_stall || $past(rsp_valid && rsp_stall) ||
          rsp_status == STATUS_OK || $past(rsp_valid)))
      else $error("load result flagged as no time");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wall-clock cache. Loads and queries are driven
// with random gaps on both channels; a scoreboard keeps its own copy of the
// stored time and predicts every answer, including the day/month/year carry.
// ----------------------------------------------------------------------------
import ceta_pkg::*;

typedef struct packed {
   logic        status;
   logic [15:0] year;
   logic [3:0]  month;
   logic [4:0]  day;
   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [5:0]  second;
} clock_reading_type;

class wall_clock_checker;
   localparam int unsigned MS_PER_SECOND = 1000;

   clock_reading_type pending_times[$];
   int unsigned       failures;

   logic        have_time;
   logic [15:0] base_year;
   logic [3:0]  base_month;
   logic [4:0]  base_day;
   logic [4:0]  base_hour;
   logic [5:0]  base_minute;
   logic [5:0]  base_second;
   logic [31:0] sync_stamp;

   function new();
      failures    = 0;
      have_time   = 1'b0;
      base_year   = 16'd0;
      base_month  = 4'd1;
      base_day    = 5'd1;
      base_hour   = 5'd0;
      base_minute = 6'd0;
      base_second = 6'd0;
      sync_stamp  = 32'd0;
   endfunction

   function bit is_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   // months outside 1..12 count as 31 days
   function int unsigned days_of_month(int unsigned mon, int unsigned y);
      case (mon)
         2:          return is_leap(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:    return 31;
      endcase
   endfunction

   function clock_reading_type advance_time(logic [31:0] now_ms);
      logic [31:0]       elapsed;
      longint unsigned   carry;
      int unsigned       y, mon, day, dim, left, hr, mn, sc;
      clock_reading_type r;
      elapsed = now_ms - sync_stamp;
      y   = base_year;
      mon = base_month;
      day = base_day;
      carry = longint'(base_second) + longint'(elapsed / MS_PER_SECOND);
      sc    = 32'(carry % 60);
      carry = base_minute + carry / 60;
      mn    = 32'(carry % 60);
      carry = base_hour + carry / 60;
      hr    = 32'(carry % 24);
      carry = carry / 24;
      while (carry > 0) begin
         dim  = days_of_month(mon, y);
         left = (day <= dim) ? dim - day + 1 : 1;
         if (day + carry <= dim) begin
            day   = 32'(day + carry);
            carry = 0;
         end else begin
            carry = carry - left;
            day   = 1;
            if (mon >= MONTH_DEC) begin
               mon = MONTH_JAN;
               y   = (y + 1) & 16'hFFFF;
            end else begin
               mon = mon + 1;
            end
         end
      end
      r.status = STATUS_OK;
      r.year   = y[15:0];
      r.month  = mon[3:0];
      r.day    = day[4:0];
      r.hour   = hr[4:0];
      r.minute = mn[5:0];
      r.second = sc[5:0];
      return r;
   endfunction

   function void note_request(logic kind, logic [31:0] now_ms, logic [15:0] y,
                              logic [3:0] mo, logic [4:0] d, logic [4:0] h,
                              logic [5:0] mi, logic [5:0] s);
      clock_reading_type r;
      if (kind == REQ_LOAD) begin
         base_year   = y;
         base_month  = mo;
         base_day    = d;
         base_hour   = h;
         base_minute = mi;
         base_second = s;
         sync_stamp  = now_ms;
         have_time   = 1'b1;
      end
      if (kind == REQ_QUERY && !have_time) begin
         r        = '0;
         r.status = STATUS_NO_TIME;
      end else begin
         r = advance_time(now_ms);
      end
      pending_times.push_back(r);
   endfunction

   function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d got %0d", $time, field, want, got);
         failures++;
      end
   endfunction

   function void check_answer(clock_reading_type got);
      clock_reading_type want;
      if (pending_times.size() == 0) begin
         $display("%0t: unexpected result, expected none got %p", $time, got);
         failures++;
         return;
      end
      want = pending_times.pop_front();
      compare("status", want.status, got.status);
      compare("year",   want.year,   got.year);
      compare("month",  want.month,  got.month);
      compare("day",    want.day,    got.day);
      compare("hour",   want.hour,   got.hour);
      compare("minute", want.minute, got.minute);
      compare("second", want.second, got.second);
   endfunction

   function int unsigned pending_count();
      return pending_times.size();
   endfunction
endclass

module tb;
   localparam int unsigned DAY_MS      = 86_400_000;
   localparam int unsigned RANDOM_ITEMS = 1900;
   localparam int unsigned HOLD_CYCLES = 400;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_type;
   logic [31:0] req_now_ms;
   logic [15:0] req_in_year;
   logic [3:0]  req_in_month;
   logic [4:0]  req_in_day;
   logic [4:0]  req_in_hour;
   logic [5:0]  req_in_minute;
   logic [5:0]  req_in_second;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_status;
   logic [15:0] rsp_out_year;
   logic [3:0]  rsp_out_month;
   logic [4:0]  rsp_out_day;
   logic [4:0]  rsp_out_hour;
   logic [5:0]  rsp_out_minute;
   logic [5:0]  rsp_out_second;

   wall_clock_checker sb = new();

   bit          calm;
   bit          hold_request;
   int unsigned hold_left;
   int unsigned rsp_wait;
   logic [31:0] last_stamp;

   calendar_elapsed_time_advance_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_now_ms     (req_now_ms),
      .req_in_year    (req_in_year),
      .req_in_month   (req_in_month),
      .req_in_day     (req_in_day),
      .req_in_hour    (req_in_hour),
      .req_in_minute  (req_in_minute),
      .req_in_second  (req_in_second),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_out_year   (rsp_out_year),
      .rsp_out_month  (rsp_out_month),
      .rsp_out_day    (rsp_out_day),
      .rsp_out_hour   (rsp_out_hour),
      .rsp_out_minute (rsp_out_minute),
      .rsp_out_second (rsp_out_second)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // entered and left at a falling edge
   task automatic send_item(input logic kind, input logic [31:0] now_ms,
                            input logic [15:0] y, input logic [3:0] mo,
                            input logic [4:0] d, input logic [4:0] h,
                            input logic [5:0] mi, input logic [5:0] s);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_type      = kind;
      req_now_ms    = now_ms;
      req_in_year   = y;
      req_in_month  = mo;
      req_in_day    = d;
      req_in_hour   = h;
      req_in_minute = mi;
      req_in_second = s;
      req_valid     = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(kind, now_ms, y, mo, d, h, mi, s);
      @(negedge clock);
   endtask

   task automatic load_time(input logic [15:0] y, input logic [3:0] mo,
                            input logic [4:0] d, input logic [4:0] h,
                            input logic [5:0] mi, input logic [5:0] s,
                            input logic [31:0] stamp);
      last_stamp = stamp;
      send_item(REQ_LOAD, stamp, y, mo, d, h, mi, s);
   endtask

   // date fields of a query carry noise; the block must ignore them
   task automatic query_time(input logic [31:0] now_ms);
      send_item(REQ_QUERY, now_ms, 16'($urandom), 4'($urandom), 5'($urandom),
                5'($urandom), 6'($urandom), 6'($urandom));
   endtask

   task automatic load_plausible();
      int unsigned y, mo, dim, d, h, mi, s;
      case ($urandom_range(0, 3))
         0:       y = $urandom_range(0, 65535);
         1:       y = 100 * $urandom_range(15, 25) + $urandom_range(0, 1);
         2:       y = 65535 - $urandom_range(0, 1);
         default: y = $urandom_range(1990, 2110);
      endcase
      mo  = $urandom_range(1, 12);
      dim = sb.days_of_month(mo, y);
      d   = $urandom_range(0, 1) ? dim : $urandom_range(1, dim);
      h   = $urandom_range(0, 1) ? 23 : $urandom_range(0, 23);
      mi  = $urandom_range(0, 1) ? 59 : $urandom_range(0, 59);
      s   = $urandom_range(0, 1) ? 59 : $urandom_range(0, 59);
      load_time(16'(y), 4'(mo), 5'(d), 5'(h), 6'(mi), 6'(s), $urandom);
   endtask

   task automatic query_random();
      logic [31:0] delta;
      case ($urandom_range(0, 3))
         0:       delta = $urandom_range(0, 5000);
         1:       delta = $urandom_range(0, 49) * DAY_MS + $urandom_range(0, 2000);
         2:       delta = $urandom;
         default: delta = 32'hFFFF_FFFF - $urandom_range(0, 5_000_000);
      endcase
      query_time(last_stamp + delta);
   endtask

   // result side: per-item stall plus one long hold-off
   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      rsp_wait  = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else if (rsp_wait > 0) begin
            rsp_stall = 1'b1;
            rsp_wait--;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_answer({rsp_status, rsp_out_year, rsp_out_month, rsp_out_day,
                          rsp_out_hour, rsp_out_minute, rsp_out_second});
         rsp_wait = calm ? 0 : $urandom_range(0, 7);
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_type      = REQ_LOAD;
      req_now_ms    = '0;
      req_in_year   = '0;
      req_in_month  = '0;
      req_in_day    = '0;
      req_in_hour   = '0;
      req_in_minute = '0;
      req_in_second = '0;
      calm          = 1'b0;
      hold_request  = 1'b0;
      last_stamp    = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // nothing stored yet
      query_time($urandom);
      // year rollover, just short of and at one second
      load_time(2023, 12, 31, 23, 59, 59, 32'h1000_0000);
      query_time(32'h1000_0000 + 999);
      query_time(32'h1000_0000 + 1000);
      // leap years: divisible by 4, by 100 only, by 400
      load_time(2024, 2, 28, 23, 59, 59, 32'h2000_0000);
      query_time(32'h2000_0000 + 1000);
      query_time(32'h2000_0000 + DAY_MS + 1000);
      load_time(1900, 2, 28, 23, 59, 59, 32'h3000_0000);
      query_time(32'h3000_0000 + 1000);
      load_time(2000, 2, 28, 23, 59, 59, 32'h4000_0000);
      query_time(32'h4000_0000 + 1000);
      // counter wrap and year wrap together, then the longest elapsed span
      load_time(16'hFFFF, 12, 31, 23, 59, 59, 32'hFFFF_FC18);
      query_time(32'h0000_0000);
      query_time(32'hFFFF_FC17);
      // oversized time fields carry in the load answer itself
      load_time(2024, 1, 15, 31, 63, 63, 32'h5000_0000);
      // month zero and month above 12
      load_time(2021, 0, 10, 12, 0, 0, 32'h6000_0000);
      query_time(32'h6000_0000 + 30 * DAY_MS);
      load_time(2021, 15, 20, 0, 0, 0, 32'h7000_0000);
      query_time(32'h7000_0000 + 15 * DAY_MS);
      // day past month end, then day zero
      load_time(2021, 2, 31, 0, 0, 0, 32'h8000_0000);
      query_time(32'h8000_0000 + DAY_MS);
      load_time(2021, 5, 0, 10, 0, 0, 32'h9000_0000);
      query_time(32'h9000_0000 + 1000);
      query_time(32'h9000_0000 + DAY_MS);
      // all fields at their maximum, then all at zero
      load_time(16'hFFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F, 32'd0);
      query_time(32'hFFFF_FFFF);
      load_time(0, 0, 0, 0, 0, 0, $urandom);

      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         int unsigned pick;
         if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
         if (n == 700) hold_request = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 20)
            load_plausible();
         else if (pick < 25)
            load_time(16'($urandom), 4'($urandom), 5'($urandom), 5'($urandom),
                      6'($urandom), 6'($urandom), $urandom);
         else
            query_random();
      end
      req_valid = 1'b0;

      while (sb.pending_count() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (sb.failures == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb NOT OK");
      $finish;
   end
endmodule
